>>> hdl/life_cell_stencil_update_assert.svh
// Assertion helpers for the life cell stencil update block.
// Both macros sample on aclk and stay quiet while aresetn is low.
`ifndef LIFE_CELL_STENCIL_UPDATE_ASSERT_SVH
`define LIFE_CELL_STENCIL_UPDATE_ASSERT_SVH

// Same-cycle implication.
`define LCSU_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LCSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/lcsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcsu_pkg;

    // Fixed field and register widths
    localparam int TILE_W_BITS     = 11;
    localparam int TILE_H_BITS     = 13;
    localparam int ROW_BITS        = 13;
    localparam int COL_IDX_BITS    = 10;
    localparam int ROW_IDX_BITS    = 12;
    localparam int MAX_TILE_HEIGHT = 4096;
    localparam int IN_TDATA_BITS   = 8;
    localparam int OUT_TDATA_BITS  = 32;
    localparam int PADDR_BITS      = 3;
    localparam int PDATA_BITS      = 32;

    // Rule B3/S23
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    localparam logic [TILE_W_BITS-1:0] TILE_W_RESET = 11'd50;
    localparam logic [TILE_H_BITS-1:0] TILE_H_RESET = 13'd50;

    // Register index
    typedef enum logic {
        REG_TILE_WIDTH  = 1'b0,
        REG_TILE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Position tag that travels with a cell into the window stage
    typedef struct packed {
        logic                    emit;
        logic                    last;
        logic [COL_IDX_BITS-1:0] col_index;
        logic [ROW_IDX_BITS-1:0] row_index;
    } cell_tag_t;

    // One result word
    typedef struct packed {
        logic                    frame_last;
        logic [ROW_IDX_BITS-1:0] row_index;
        logic [COL_IDX_BITS-1:0] col_index;
        logic                    any_change;
        logic                    cell_changed;
        logic                    next_alive;
    } cell_result_t;

endpackage

`default_nettype wire

>>> hdl/life_cell_stencil_update.sv
// Streaming Game of Life (B3/S23) update: feed one tile of the current
// generation, halo ring included, in raster order on s_, one cell per word in
// s_tdata[0]; the block returns one word per interior cell on m_ with its next
// state, a changed flag, a running any-change flag for the frame and its
// position, and m_tlast on the last interior cell. It takes one cell per clock
// while the window stage is not held by a full output, and a result passes
// through the window stage register and the skid output register. The rate is
// set by the single line memory (MAX_TILE_WIDTH+2 entries of two bits, the two
// rows above the incoming one), which takes one read and one write of another
// entry each cycle that cells flow. The memory needs no clearing after reset. Write
// tile_width (byte address 0) and tile_height (byte address 4) only between
// frames; any write restarts the frame. Zero acts as 1 and values above the
// maximum are clamped.
`timescale 1ns / 1ps
`default_nettype none

module life_cell_stencil_update #(
    parameter int MAX_TILE_WIDTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input cells
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lcsu_pkg::IN_TDATA_BITS-1:0]   s_tdata,  // [0] cell_alive
    // Results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] next_alive, [1] cell_changed, [2] any_change, [12:3] col_index,
    // [24:13] row_index, [31:25] zero
    output logic [lcsu_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    output logic                                 m_tlast,  // frame_last
    // Configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lcsu_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [lcsu_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [lcsu_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                 pready
);
    import lcsu_pkg::*;
    `include "life_cell_stencil_update_assert.svh"

    localparam int DEPTH = MAX_TILE_WIDTH + 2;
    localparam int CW    = $clog2(DEPTH);

    logic [TILE_W_BITS-1:0] tile_width_reg, tile_width_next;
    logic [TILE_H_BITS-1:0] tile_height_reg, tile_height_next;
    cfg_reg_t               cfg_index;
    logic                   cfg_write;

    logic          accept;
    logic [CW-1:0] scan_addr;
    cell_tag_t     scan_tag;
    logic          s1_busy, skid_full;
    logic          mem_we;
    logic [CW-1:0] mem_waddr;
    logic [1:0]    mem_wdata, mem_rdata;
    logic          res_valid;
    cell_result_t  res, out_res;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_index = cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        tile_width_next  = tile_width_reg;
        tile_height_next = tile_height_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                REG_TILE_WIDTH:  tile_width_next  = pwdata[TILE_W_BITS-1:0];
                REG_TILE_HEIGHT: tile_height_next = pwdata[TILE_H_BITS-1:0];
                default:         tile_width_next  = tile_width_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_TILE_WIDTH:  prdata = PDATA_BITS'(tile_width_reg);
            REG_TILE_HEIGHT: prdata = PDATA_BITS'(tile_height_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_width_reg  <= TILE_W_RESET;
            tile_height_reg <= TILE_H_RESET;
        end else begin
            tile_width_reg  <= tile_width_next;
            tile_height_reg <= tile_height_next;
        end
    end

    // Hold input while the window stage waits on a full output
    assign s_tready = !(s1_busy && skid_full);
    assign accept   = s_tvalid && s_tready;

    lcsu_scan #(
        .MAX_TILE_WIDTH (MAX_TILE_WIDTH),
        .CW             (CW)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .restart     (cfg_write),
        .advance     (accept),
        .tile_width  (tile_width_reg),
        .tile_height (tile_height_reg),
        .addr        (scan_addr),
        .tag         (scan_tag)
    );

    lcsu_line_mem #(
        .DEPTH (DEPTH),
        .AW    (CW)
    ) u_line_mem (
        .aclk  (aclk),
        .re    (accept),
        .raddr (scan_addr),
        .rdata (mem_rdata),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata)
    );

    lcsu_window #(
        .CW (CW)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .restart     (cfg_write),
        .accept      (accept),
        .accept_addr (scan_addr),
        .accept_tag  (scan_tag),
        .accept_cell (s_tdata[0]),
        .hold        (skid_full),
        .rdata       (mem_rdata),
        .busy        (s1_busy),
        .we          (mem_we),
        .waddr       (mem_waddr),
        .wdata       (mem_wdata),
        .res_valid   (res_valid),
        .res         (res)
    );

    lcsu_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .full      (skid_full),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    // Pack the result word
    assign m_tdata = OUT_TDATA_BITS'({out_res.row_index, out_res.col_index,
                                      out_res.any_change, out_res.cell_changed,
                                      out_res.next_alive});
    assign m_tlast = out_res.frame_last;

    `LCSU_ASSERT_IMPLIES(a_mem_no_collision, mem_we && accept, mem_waddr != scan_addr,
        "line memory read and write hit the same entry")
    `LCSU_ASSERT_IMPLIES(a_change_implies_any, m_tvalid && m_tdata[1], m_tdata[2],
        "changed cell without any-change flag")
    `LCSU_ASSERT_NEXT(a_window_holds, s1_busy && skid_full, s1_busy,
        "window stage dropped a cell while stalled")
    `LCSU_ASSERT_IMPLIES(a_skid_no_overrun, skid_full, !res_valid,
        "result pushed into a full skid stage")

endmodule

`default_nettype wire

>>> hdl/lcsu_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module lcsu_line_mem #(
    parameter int DEPTH = 1026,
    parameter int AW    = 11
) (
    input  logic          aclk,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [1:0]    rdata,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wdata
);

    // Bit 1: two rows above, bit 0: one row above
    logic [1:0] mem [DEPTH];
    logic [1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, hold data while idle
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/lcsu_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module lcsu_scan #(
    parameter int MAX_TILE_WIDTH = 1024,
    parameter int CW             = 11
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          restart,
    input  logic                          advance,
    input  logic [lcsu_pkg::TILE_W_BITS-1:0] tile_width,
    input  logic [lcsu_pkg::TILE_H_BITS-1:0] tile_height,
    output logic [CW-1:0]                 addr,
    output lcsu_pkg::cell_tag_t           tag
);
    import lcsu_pkg::*;

    localparam int EW = ((CW > TILE_W_BITS) ? CW : TILE_W_BITS) + 1;
    localparam int HW = TILE_H_BITS + 1;

    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [EW-1:0]       w_ext, w_eff;
    logic [HW-1:0]       h_ext, h_eff;
    logic [CW-1:0]       col_last, c;
    logic [ROW_BITS-1:0] row_last, r;

    // Clamp the tile size and find the last padded column and row
    always_comb begin
        w_ext = EW'(tile_width);
        h_ext = HW'(tile_height);
        if (w_ext == '0) begin
            w_eff = EW'(1);
        end else if (w_ext > EW'(MAX_TILE_WIDTH)) begin
            w_eff = EW'(MAX_TILE_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext == '0) begin
            h_eff = HW'(1);
        end else if (h_ext > HW'(MAX_TILE_HEIGHT)) begin
            h_eff = HW'(MAX_TILE_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
        col_last = CW'(w_eff + EW'(1));
        row_last = ROW_BITS'(h_eff + HW'(1));
    end

    // Current position, wrapped back into the frame
    always_comb begin
        c = (col_reg > col_last) ? '0 : col_reg;
        r = (row_reg > row_last) ? '0 : row_reg;
        addr          = c;
        tag.emit      = (c >= CW'(2)) && (r >= ROW_BITS'(2));
        tag.last      = (c == col_last) && (r == row_last);
        tag.col_index = COL_IDX_BITS'(c - CW'(2));
        tag.row_index = ROW_IDX_BITS'(r - ROW_BITS'(2));
    end

    // Advance the raster position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (advance) begin
            if (c == col_last) begin
                col_next = '0;
                row_next = (r == row_last) ? '0 : r + ROW_BITS'(1);
            end else begin
                col_next = c + CW'(1);
                row_next = r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lcsu_window.sv
`timescale 1ns / 1ps
`default_nettype none

module lcsu_window #(
    parameter int CW = 11
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    restart,
    input  logic                    accept,
    input  logic [CW-1:0]           accept_addr,
    input  lcsu_pkg::cell_tag_t     accept_tag,
    input  logic                    accept_cell,
    input  logic                    hold,
    input  logic [1:0]              rdata,
    output logic                    busy,
    output logic                    we,
    output logic [CW-1:0]           waddr,
    output logic [1:0]              wdata,
    output logic                    res_valid,
    output lcsu_pkg::cell_result_t  res
);
    import lcsu_pkg::*;

    logic            s1_valid_reg, s1_valid_next;
    logic [CW-1:0]   s1_addr_reg;
    cell_tag_t       s1_tag_reg;
    logic            s1_cell_reg;
    logic [8:0]      window_reg, window_next;
    logic            seen_reg, seen_next;
    logic            advance;
    logic [8:0]      window_new;
    logic [3:0]      count;
    logic            center, alive, changed, any_now;

    assign advance = s1_valid_reg && !hold;
    assign busy    = s1_valid_reg;

    // Capture the cell whose line-store read is in flight
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg <= accept_addr;
            s1_tag_reg  <= accept_tag;
            s1_cell_reg <= accept_cell;
        end
    end

    // Shift in the new column and apply the rule
    always_comb begin
        window_new = {s1_cell_reg, rdata[0], rdata[1], window_reg[8:3]};
        center     = window_new[4];
        count      = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                count = count + 4'(window_new[i]);
            end
        end
        alive   = (count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && center);
        changed = alive ^ center;
        any_now = seen_reg | changed;
    end

    // Write back: row above moves to two above, new cell to row above
    assign we    = advance;
    assign waddr = s1_addr_reg;
    assign wdata = {rdata[0], s1_cell_reg};

    assign res_valid        = advance && s1_tag_reg.emit;
    assign res.next_alive   = alive;
    assign res.cell_changed = changed;
    assign res.any_change   = any_now;
    assign res.col_index    = s1_tag_reg.col_index;
    assign res.row_index    = s1_tag_reg.row_index;
    assign res.frame_last   = s1_tag_reg.last;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        window_next   = window_reg;
        seen_next     = seen_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        if (restart) begin
            window_next = '0;
            seen_next   = 1'b0;
        end else if (advance) begin
            window_next = window_new;
            if (s1_tag_reg.emit) begin
                // Drop the change flag once the frame is done
                seen_next = s1_tag_reg.last ? 1'b0 : any_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            window_reg   <= '0;
            seen_reg     <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            window_reg   <= window_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lcsu_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module lcsu_skid (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  lcsu_pkg::cell_result_t in_data,
    output logic                   full,
    output logic                   out_valid,
    output lcsu_pkg::cell_result_t out_data,
    input  logic                   out_ready
);
    import lcsu_pkg::*;

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    cell_result_t main_reg, main_next;
    cell_result_t skid_reg, skid_next;

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Refill the output word from the skid first, park a word when stalled
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_valid;
                main_next       = in_data;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

endmodule

`default_nettype wire
